/* src/pcms_pkg.sv */
// ----------------------------------------------------------------------------
// pcms_pkg: shared constants for the partition count modulus search
// Widths of the request, result and register fields, and parameter defaults.
// ----------------------------------------------------------------------------
package pcms_pkg;

   localparam int MaxNDefault = 65536;
   localparam int ValW        = 20;
   localparam int ModW        = 21;
   localparam int LimW        = 17;

   localparam logic [ModW-1:0] ModCap   = 21'd1048576;
   localparam logic [ModW-1:0] ModReset = 21'd1000000;

endpackage

/* src/pcms_table.sv */
// ----------------------------------------------------------------------------
// pcms_table: partition value store
// One write port and one registered read port; entry zero is supplied from
// the current modulus instead of from the array.
// ----------------------------------------------------------------------------
module pcms_table import pcms_pkg::*; #(
   parameter int MAX_N  = MaxNDefault,
   localparam int ADDR_W = $clog2(MAX_N)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ValW-1:0]   wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              entry0_zero,
   output logic [ValW-1:0]   rd_data
);

   logic [ValW-1:0] mem_ff [MAX_N];
   logic [ValW-1:0] rdata_ff;
   logic            zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
         zero_ff  <= (rd_addr == '0);
      end
   end

   // p(0) is 1, which reduces to 0 only for a modulus of one
   assign rd_data = zero_ff ? (entry0_zero ? '0 : ValW'(1)) : rdata_ff;

endmodule

/* src/partition_count_mod_search_unit.sv */
// ----------------------------------------------------------------------------
// partition_count_mod_search_unit: least n with p(n) divisible by a modulus
// Builds p(n) mod m by the pentagonal recurrence, one table term per cycle.
// ----------------------------------------------------------------------------
//   channel  | ports                                    | flow
//   ---------+------------------------------------------+----------------------
//   request  | start, busy, req_search_limit            | taken on start & !busy
//   result   | rsp_valid, rsp_found_n, rsp_found        | one-cycle strobe
//   csr      | csr_wr_en, csr_wr_data                   | written on csr_wr_en
//
// Each n examined needs T(n) table terms, where T(n) is the number of
// pentagonal terms of p(n) (about 1.6 sqrt(n)), read one term per cycle
// through the single table read port and the shared modular adder. A zero
// limit or zero modulus is answered in the next cycle without raising busy.
// busy stays high until the result strobe. Reset clears the sequencer and
// sets the modulus to 1000000; the result side cannot stall.
module partition_count_mod_search_unit import pcms_pkg::*; #(
   parameter int MAX_N = MaxNDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [LimW-1:0] req_search_limit,
   output logic            rsp_valid,
   output logic [LimW-1:0] rsp_found_n,
   output logic            rsp_found,
   input  logic            csr_wr_en,
   input  logic [ModW-1:0] csr_wr_data
);

   localparam int N_W    = $clog2(MAX_N + 1);
   localparam int ADDR_W = $clog2(MAX_N);
   localparam int OFF_W  = N_W + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WRAP} state_type;

   state_type       state_ff, state_in;
   logic [N_W-1:0]  n_ff, n_in, lim_ff, lim_in;
   logic [ModW-1:0] m_ff, m_in, modulus_ff, modulus_in;
   logic [ValW-1:0] sum_ff, sum_in;
   logic [OFF_W-1:0] off_ff [2];
   logic [OFF_W-1:0] off_in [2];
   logic [OFF_W-1:0] gap_ff [2];
   logic [OFF_W-1:0] gap_in [2];
   logic [1:0]      phase_ff, phase_in;
   logic            pend_ff, pend_in, pend_neg_ff, pend_neg_in;
   logic            rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic [LimW-1:0] rsp_found_n_ff, rsp_found_n_in;

   logic [31:0]     lim_wide;
   logic [ModW-1:0] m_sat;
   logic            run_sel, issue;
   logic            rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ValW-1:0] rd_data;
   logic [ModW-1:0] acc_sum, acc_pos, acc_diff, acc_neg;
   logic [ValW-1:0] acc_next;

   pcms_table #(.MAX_N(MAX_N)) u_table (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (ADDR_W'(n_ff)),
      .wr_data     (sum_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .entry0_zero (m_ff == ModW'(1)),
      .rd_data     (rd_data)
   );

   // shared modular adder: every term lands back below the modulus
   always_comb begin
      acc_sum  = {1'b0, sum_ff} + {1'b0, rd_data};
      acc_pos  = (acc_sum >= m_ff) ? acc_sum - m_ff : acc_sum;
      acc_diff = {1'b0, sum_ff} - {1'b0, rd_data};
      acc_neg  = (sum_ff < rd_data) ? acc_diff + m_ff : acc_diff;
      acc_next = pend_neg_ff ? acc_neg[ValW-1:0] : acc_pos[ValW-1:0];
   end

   assign lim_wide = (32'(req_search_limit) > 32'(MAX_N)) ? 32'(MAX_N)
                                                          : 32'(req_search_limit);
   assign m_sat    = (modulus_ff > ModCap) ? ModCap : modulus_ff;
   assign run_sel  = phase_ff[0];
   assign issue    = (state_ff == ST_RUN) && (off_ff[run_sel] <= OFF_W'(n_ff));
   assign rd_en    = issue;
   assign rd_addr  = ADDR_W'(OFF_W'(n_ff) - off_ff[run_sel]);
   assign wr_en    = (state_ff == ST_WRAP) && (sum_ff != '0) && (n_ff != lim_ff);

   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      lim_in         = lim_ff;
      m_in           = m_ff;
      sum_in         = sum_ff;
      off_in         = off_ff;
      gap_in         = gap_ff;
      phase_in       = phase_ff;
      pend_in        = 1'b0;
      pend_neg_in    = pend_neg_ff;
      rsp_valid_in   = 1'b0;
      rsp_found_in   = rsp_found_ff;
      rsp_found_n_in = rsp_found_n_ff;
      modulus_in     = csr_wr_en ? csr_wr_data : modulus_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lim_in    = N_W'(lim_wide);
               m_in      = m_sat;
               n_in      = N_W'(1);
               sum_in    = '0;
               phase_in  = '0;
               off_in[0] = OFF_W'(1);
               off_in[1] = OFF_W'(2);
               gap_in[0] = OFF_W'(4);
               gap_in[1] = OFF_W'(5);
               if ((m_sat == '0) || (lim_wide == '0)) begin
                  rsp_valid_in   = 1'b1;
                  rsp_found_in   = 1'b0;
                  rsp_found_n_in = '0;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // fold the term read last cycle while issuing the next one
            if (pend_ff) begin
               sum_in = acc_next;
            end
            if (issue) begin
               off_in[run_sel] = off_ff[run_sel] + gap_ff[run_sel];
               gap_in[run_sel] = gap_ff[run_sel] + OFF_W'(3);
               phase_in        = phase_ff + 2'd1;
               pend_in         = 1'b1;
               pend_neg_in     = phase_ff[1];
            end else begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (sum_ff == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = 1'b1;
               rsp_found_n_in = LimW'(n_ff);
               state_in       = ST_IDLE;
            end else if (n_ff == lim_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = 1'b0;
               rsp_found_n_in = '0;
               state_in       = ST_IDLE;
            end else begin
               n_in      = n_ff + N_W'(1);
               sum_in    = '0;
               phase_in  = '0;
               off_in[0] = OFF_W'(1);
               off_in[1] = OFF_W'(2);
               gap_in[0] = OFF_W'(4);
               gap_in[1] = OFF_W'(5);
               state_in  = ST_RUN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= ModReset;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
      n_ff           <= n_in;
      lim_ff         <= lim_in;
      m_ff           <= m_in;
      sum_ff         <= sum_in;
      off_ff         <= off_in;
      gap_ff         <= gap_in;
      phase_ff       <= phase_in;
      pend_neg_ff    <= pend_neg_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_found_n_ff <= rsp_found_n_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_found_n = rsp_found_n_ff;

   a_taken_goes_busy_or_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request accepted without work or answer");

   a_not_found_reports_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_n == '0))
      else $error("miss reported with nonzero n");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_found_n != '0))
      else $error("hit reported with n of zero");

   a_sum_below_modulus: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_WRAP) |-> ({1'b0, sum_ff} < m_ff))
      else $error("running sum escaped the modulus");

   a_n_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((n_ff != '0) && (n_ff <= lim_ff)))
      else $error("n outside the search range");

endmodule
